### design/terrain_height_texture_weights_macros.svh
// ----------------------------------------------------------------------------
// Terrain height texture weights: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_HEIGHT_TEXTURE_WEIGHTS_MACROS_SVH
`define TERRAIN_HEIGHT_TEXTURE_WEIGHTS_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define THTW_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked after a delay of dly from the antecedent.
`define THTW_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

### design/thtw_pkg.sv
// ----------------------------------------------------------------------------
// Terrain height texture weights: shared package
// Field widths, fixed-point constants, register codes and inter-stage types.
// ----------------------------------------------------------------------------
package thtw_pkg;

  localparam int GRID_BITS     = 12;
  localparam int RECIP_BITS    = 24;
  localparam int PIX_SUM_BITS  = 10;
  localparam int HEIGHT_BITS   = 14;
  localparam int TEX_BITS      = 16;
  localparam int CFG_BITS      = 16;
  localparam int WGT_BITS      = 17;
  localparam int SUM_BITS      = 19;
  localparam int DIST_BITS     = 19;
  localparam int RAMP_PROD_BITS = 33;
  localparam int RAMPS         = 6;
  localparam int LANES         = 4;

  localparam int LANE_SAND  = 0;
  localparam int LANE_GRASS = 1;
  localparam int LANE_ROCK  = 2;
  localparam int LANE_SNOW  = 3;

  // Height is floor(sum * 256 / 18), done as sum * ceil(2^20 / 9) >> 13.
  localparam int HEIGHT_RECIP_BITS = 17;
  localparam logic [HEIGHT_RECIP_BITS-1:0] HEIGHT_RECIP = 17'd116509;
  localparam int HEIGHT_SHIFT = 13;

  localparam logic signed [DIST_BITS-1:0] THIRD_Q8      = 19'sd3627;
  localparam logic signed [DIST_BITS-1:0] TWO_THIRDS_Q8 = 19'sd7253;
  localparam logic [WGT_BITS-1:0] ONE_Q16 = 17'd65536;
  localparam logic [SUM_BITS-1:0] NORM_SLACK = 19'd3;

  localparam logic [CFG_BITS-1:0]   BLEND_WIDTH_RST  = 16'd341;
  localparam logic [CFG_BITS-1:0]   BAND_GAP_RST     = 16'd1984;
  localparam logic [CFG_BITS-1:0]   RECIP_GAP_RST    = 16'd8456;
  localparam logic [RECIP_BITS-1:0] RECIP_WIDTH_RST  = 24'd65536;
  localparam logic [RECIP_BITS-1:0] RECIP_HEIGHT_RST = 24'd65536;

  typedef enum logic [2:0] {
    CFG_BLEND_WIDTH  = 3'd0,
    CFG_BAND_GAP     = 3'd1,
    CFG_RECIP_GAP    = 3'd2,
    CFG_RECIP_WIDTH  = 3'd3,
    CFG_RECIP_HEIGHT = 3'd4
  } cfg_reg_t;

  localparam int FRONT_STAGES = 3;
  localparam int WGT_STAGES   = 5;
  localparam int DIV_STAGES   = 17;
  localparam int PIPE_LATENCY = FRONT_STAGES + WGT_STAGES + DIV_STAGES + 1;

  typedef struct packed {
    logic [RECIP_BITS-1:0] recip_width;
    logic [RECIP_BITS-1:0] recip_height;
  } thtw_coord_cfg_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] blend_width;
    logic [CFG_BITS-1:0] band_gap;
    logic [CFG_BITS-1:0] recip_gap;
  } thtw_band_cfg_t;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height;
    logic [TEX_BITS-1:0]    tex_u;
    logic [TEX_BITS-1:0]    tex_v;
  } thtw_side_t;

  typedef struct packed {
    logic       valid;
    thtw_side_t side;
  } thtw_front_t;

  typedef struct packed {
    logic                             valid;
    thtw_side_t                       side;
    logic [LANES-1:0][WGT_BITS-1:0]   w;
    logic [SUM_BITS-1:0]              sum;
  } thtw_wgt_t;

  typedef struct packed {
    logic                             valid;
    thtw_side_t                       side;
    logic                             zero;
    logic [LANES-1:0][WGT_BITS-1:0]   q;
  } thtw_res_t;

endpackage

### design/thtw_front.sv
// ----------------------------------------------------------------------------
// Terrain height texture weights: front stages
// Captures a pixel, then forms the Q8 height and the saturated Q0.16 texture
// coordinates over three register stages.
// ----------------------------------------------------------------------------
module thtw_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_fire,
  input  logic [7:0]                                pixel_blue,
  input  logic [7:0]                                pixel_green,
  input  logic [7:0]                                pixel_red,
  input  logic [thtw_pkg::GRID_BITS-1:0]            grid_column,
  input  logic [thtw_pkg::GRID_BITS-1:0]            grid_row,
  input  thtw_pkg::thtw_coord_cfg_t                 coord_cfg,
  output thtw_pkg::thtw_front_t                     front
);

  localparam int CB = (COORD_BITS < thtw_pkg::GRID_BITS) ? COORD_BITS : thtw_pkg::GRID_BITS;
  localparam int PW = CB + thtw_pkg::RECIP_BITS;
  localparam int HW = thtw_pkg::PIX_SUM_BITS + thtw_pkg::HEIGHT_RECIP_BITS;

  logic [thtw_pkg::FRONT_STAGES-1:0]  vld_r;
  logic [thtw_pkg::PIX_SUM_BITS-1:0]  psum_r;
  logic [CB-1:0]                      col_r;
  logic [CB-1:0]                      row_r;
  logic [HW-1:0]                      hprod_r;
  logic [PW-1:0]                      uprod_r;
  logic [PW-1:0]                      vprod_r;
  thtw_pkg::thtw_side_t               side_r;

  logic [thtw_pkg::PIX_SUM_BITS-1:0]  psum_nxt;
  logic [HW-1:0]                      hprod_nxt;
  logic [PW-1:0]                      uprod_nxt;
  logic [PW-1:0]                      vprod_nxt;
  thtw_pkg::thtw_side_t               side_nxt;

  always_comb begin
    psum_nxt = thtw_pkg::PIX_SUM_BITS'(pixel_blue) + thtw_pkg::PIX_SUM_BITS'(pixel_green)
             + thtw_pkg::PIX_SUM_BITS'(pixel_red);
    hprod_nxt = HW'(psum_r) * HW'(thtw_pkg::HEIGHT_RECIP);
    uprod_nxt = PW'(col_r) * PW'(coord_cfg.recip_width);
    vprod_nxt = PW'(row_r) * PW'(coord_cfg.recip_height);
    side_nxt.height = hprod_r[thtw_pkg::HEIGHT_SHIFT +: thtw_pkg::HEIGHT_BITS];
    side_nxt.tex_u  = (|uprod_r[PW-1:thtw_pkg::RECIP_BITS]) ? '1 : uprod_r[23:8];
    side_nxt.tex_v  = (|vprod_r[PW-1:thtw_pkg::RECIP_BITS]) ? '1 : vprod_r[23:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[thtw_pkg::FRONT_STAGES-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    psum_r  <= psum_nxt;
    col_r   <= grid_column[CB-1:0];
    row_r   <= grid_row[CB-1:0];
    hprod_r <= hprod_nxt;
    uprod_r <= uprod_nxt;
    vprod_r <= vprod_nxt;
    side_r  <= side_nxt;
  end

  assign front.valid = vld_r[thtw_pkg::FRONT_STAGES-1];
  assign front.side  = side_r;

endmodule

### design/thtw_weights.sv
// ----------------------------------------------------------------------------
// Terrain height texture weights: band weight stages
// Forms the six ramp distances, scales and clamps them, and builds the four
// raw band weights and their sum over five register stages.
// ----------------------------------------------------------------------------
module thtw_weights (
  input  logic                      clk,
  input  logic                      rst_n,
  input  thtw_pkg::thtw_band_cfg_t  band_cfg,
  input  thtw_pkg::thtw_front_t     front,
  output thtw_pkg::thtw_wgt_t       wgt
);

  localparam int DB = thtw_pkg::DIST_BITS;
  localparam int PB = thtw_pkg::RAMP_PROD_BITS;
  localparam int WB = thtw_pkg::WGT_BITS;

  logic [thtw_pkg::WGT_STAGES-1:0]    vld_r;
  thtw_pkg::thtw_side_t               side_r [thtw_pkg::WGT_STAGES];

  logic signed [DB-1:0]               dist_r [thtw_pkg::RAMPS];
  logic [PB-1:0]                      prod_r [thtw_pkg::RAMPS];
  logic [WB-1:0]                      ramp_r [thtw_pkg::RAMPS];
  logic [thtw_pkg::LANES-1:0][WB-1:0] raw_r;
  logic [thtw_pkg::LANES-1:0][WB-1:0] w_r;
  logic [thtw_pkg::SUM_BITS-1:0]      sum_r;

  logic signed [DB-1:0]               dist_nxt [thtw_pkg::RAMPS];
  logic [PB-1:0]                      prod_nxt [thtw_pkg::RAMPS];
  logic [WB-1:0]                      ramp_nxt [thtw_pkg::RAMPS];
  logic [thtw_pkg::LANES-1:0][WB-1:0] raw_nxt;
  logic [thtw_pkg::SUM_BITS-1:0]      sum_nxt;
  logic signed [DB-1:0]               ys;
  logic signed [DB-1:0]               gs;
  logic signed [DB-1:0]               bs;

  always_comb begin
    ys = $signed({5'd0, front.side.height});
    gs = $signed({3'd0, band_cfg.band_gap});
    bs = $signed({3'd0, band_cfg.blend_width});
    dist_nxt[0] = ys;
    dist_nxt[1] = ys - gs + bs;
    dist_nxt[2] = ys - thtw_pkg::THIRD_Q8;
    dist_nxt[3] = ys - gs - thtw_pkg::THIRD_Q8 + bs;
    dist_nxt[4] = ys - thtw_pkg::TWO_THIRDS_Q8;
    dist_nxt[5] = ys - gs - thtw_pkg::TWO_THIRDS_Q8 + bs;
  end

  always_comb begin
    for (int i = 0; i < thtw_pkg::RAMPS; i++) begin
      if (!dist_r[i][DB-1] && (dist_r[i] != '0)) begin
        prod_nxt[i] = PB'(dist_r[i][16:0]) * PB'(band_cfg.recip_gap);
      end else begin
        prod_nxt[i] = '0;
      end
      ramp_nxt[i] = (prod_r[i][PB-1:8] > 25'(thtw_pkg::ONE_Q16)) ? thtw_pkg::ONE_Q16
                                                                 : prod_r[i][24:8];
    end
  end

  always_comb begin
    raw_nxt[thtw_pkg::LANE_SAND]  = thtw_pkg::ONE_Q16 - ramp_r[0];
    raw_nxt[thtw_pkg::LANE_GRASS] = (ramp_r[1] > ramp_r[2]) ? ramp_r[1] - ramp_r[2] : '0;
    raw_nxt[thtw_pkg::LANE_ROCK]  = (ramp_r[3] > ramp_r[4]) ? ramp_r[3] - ramp_r[4] : '0;
    raw_nxt[thtw_pkg::LANE_SNOW]  = ramp_r[5];
    sum_nxt = thtw_pkg::SUM_BITS'(raw_r[0]) + thtw_pkg::SUM_BITS'(raw_r[1])
            + thtw_pkg::SUM_BITS'(raw_r[2]) + thtw_pkg::SUM_BITS'(raw_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[thtw_pkg::WGT_STAGES-2:0], front.valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= front.side;
    for (int s = 1; s < thtw_pkg::WGT_STAGES; s++) begin
      side_r[s] <= side_r[s-1];
    end
    for (int i = 0; i < thtw_pkg::RAMPS; i++) begin
      dist_r[i] <= dist_nxt[i];
      prod_r[i] <= prod_nxt[i];
      ramp_r[i] <= ramp_nxt[i];
    end
    raw_r <= raw_nxt;
    w_r   <= raw_r;
    sum_r <= sum_nxt;
  end

  assign wgt.valid = vld_r[thtw_pkg::WGT_STAGES-1];
  assign wgt.side  = side_r[thtw_pkg::WGT_STAGES-1];
  assign wgt.w     = w_r;
  assign wgt.sum   = sum_r;

endmodule

### design/thtw_div.sv
// ----------------------------------------------------------------------------
// Terrain height texture weights: weight normalizer
// Restoring divider, one quotient bit per stage and four lanes sharing the
// divisor, giving floor(w * 65536 / sum) after seventeen stages.
// ----------------------------------------------------------------------------
module thtw_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  thtw_pkg::thtw_wgt_t  wgt,
  output thtw_pkg::thtw_res_t  res
);

  localparam int SB = thtw_pkg::SUM_BITS;
  localparam int WB = thtw_pkg::WGT_BITS;
  localparam int NS = thtw_pkg::DIV_STAGES;

  typedef struct packed {
    thtw_pkg::thtw_side_t               side;
    logic                               zero;
    logic [SB-1:0]                      sum;
    logic [thtw_pkg::LANES-1:0][SB-1:0] rem;
    logic [thtw_pkg::LANES-1:0][WB-1:0] q;
  } div_stage_t;

  logic [NS-1:0] vld_r;
  div_stage_t    stg_r   [NS];
  div_stage_t    stg_nxt [NS];

  function automatic logic [SB:0] div_step(input logic [SB-1:0] rem_in, input logic bit_in,
                                           input logic [SB-1:0] divisor);
    logic [SB:0] trial;
    logic [SB:0] diff;
    trial = {rem_in, bit_in};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      return {1'b1, diff[SB-1:0]};
    end else begin
      return {1'b0, trial[SB-1:0]};
    end
  endfunction

  always_comb begin
    logic [SB:0] step;
    stg_nxt[0].side = wgt.side;
    stg_nxt[0].zero = (wgt.sum == '0);
    stg_nxt[0].sum  = wgt.sum;
    for (int l = 0; l < thtw_pkg::LANES; l++) begin
      step = div_step(SB'(wgt.w[l][WB-1:1]), wgt.w[l][0], wgt.sum);
      stg_nxt[0].rem[l] = step[SB-1:0];
      stg_nxt[0].q[l]   = WB'(step[SB]);
    end
    for (int s = 1; s < NS; s++) begin
      stg_nxt[s].side = stg_r[s-1].side;
      stg_nxt[s].zero = stg_r[s-1].zero;
      stg_nxt[s].sum  = stg_r[s-1].sum;
      for (int l = 0; l < thtw_pkg::LANES; l++) begin
        step = div_step(stg_r[s-1].rem[l], 1'b0, stg_r[s-1].sum);
        stg_nxt[s].rem[l] = step[SB-1:0];
        stg_nxt[s].q[l]   = {stg_r[s-1].q[l][WB-2:0], step[SB]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], wgt.valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      stg_r[s] <= stg_nxt[s];
    end
  end

  assign res.valid = vld_r[NS-1];
  assign res.side  = stg_r[NS-1].side;
  assign res.zero  = stg_r[NS-1].zero;
  assign res.q     = stg_r[NS-1].q;

endmodule

### design/terrain_height_texture_weights.sv
// ----------------------------------------------------------------------------
// Terrain height texture weights: top level
// One heightmap pixel in, its height, texture coordinates and four
// normalized band weights out.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock where start is high and busy is low; busy
// is high only during reset and in the cycle right after it, so the block
// takes one pixel per cycle without gaps. Every pixel gives exactly one
// result, shown on the out_ ports for one cycle with out_valid high; results
// leave in input order and cannot be held off by the receiver. A pixel passes
// through three front stages, five weight stages, the seventeen-stage weight
// normalizer (one quotient bit per stage) and the output register. The cfg_
// registers are to be written only while no pixel is in flight.
module terrain_height_texture_weights #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [7:0]                            in_pixel_blue,
  input  logic [7:0]                            in_pixel_green,
  input  logic [7:0]                            in_pixel_red,
  input  logic [thtw_pkg::GRID_BITS-1:0]        in_grid_column,
  input  logic [thtw_pkg::GRID_BITS-1:0]        in_grid_row,
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_index,
  input  logic [thtw_pkg::RECIP_BITS-1:0]       cfg_data,
  output logic                                  out_valid,
  output logic [thtw_pkg::HEIGHT_BITS-1:0]      out_terrain_height_q8,
  output logic [thtw_pkg::TEX_BITS-1:0]         out_tex_u_q16,
  output logic [thtw_pkg::TEX_BITS-1:0]         out_tex_v_q16,
  output logic [thtw_pkg::WGT_BITS-1:0]         out_weight_sand,
  output logic [thtw_pkg::WGT_BITS-1:0]         out_weight_grass,
  output logic [thtw_pkg::WGT_BITS-1:0]         out_weight_rock,
  output logic [thtw_pkg::WGT_BITS-1:0]         out_weight_snow,
  output logic                                  out_weights_zero
);

`include "terrain_height_texture_weights_macros.svh"

  logic                                  busy_r;
  logic [thtw_pkg::CFG_BITS-1:0]         blend_width_r;
  logic [thtw_pkg::CFG_BITS-1:0]         band_gap_r;
  logic [thtw_pkg::CFG_BITS-1:0]         recip_gap_r;
  logic [thtw_pkg::RECIP_BITS-1:0]       recip_width_r;
  logic [thtw_pkg::RECIP_BITS-1:0]       recip_height_r;

  logic                                  out_valid_r;
  logic [thtw_pkg::HEIGHT_BITS-1:0]      out_height_r;
  logic [thtw_pkg::TEX_BITS-1:0]         out_tex_u_r;
  logic [thtw_pkg::TEX_BITS-1:0]         out_tex_v_r;
  logic [thtw_pkg::LANES-1:0][thtw_pkg::WGT_BITS-1:0] out_w_r;
  logic                                  out_zero_r;

  logic                                  in_fire;
  thtw_pkg::thtw_coord_cfg_t             coord_cfg;
  thtw_pkg::thtw_band_cfg_t              band_cfg;
  thtw_pkg::thtw_front_t                 front;
  thtw_pkg::thtw_wgt_t                   wgt;
  thtw_pkg::thtw_res_t                   res;
  logic [thtw_pkg::SUM_BITS-1:0]         out_wsum;

  assign in_fire = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b1;
      blend_width_r  <= thtw_pkg::BLEND_WIDTH_RST;
      band_gap_r     <= thtw_pkg::BAND_GAP_RST;
      recip_gap_r    <= thtw_pkg::RECIP_GAP_RST;
      recip_width_r  <= thtw_pkg::RECIP_WIDTH_RST;
      recip_height_r <= thtw_pkg::RECIP_HEIGHT_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          thtw_pkg::CFG_BLEND_WIDTH:  blend_width_r  <= cfg_data[thtw_pkg::CFG_BITS-1:0];
          thtw_pkg::CFG_BAND_GAP:     band_gap_r     <= cfg_data[thtw_pkg::CFG_BITS-1:0];
          thtw_pkg::CFG_RECIP_GAP:    recip_gap_r    <= cfg_data[thtw_pkg::CFG_BITS-1:0];
          thtw_pkg::CFG_RECIP_WIDTH:  recip_width_r  <= cfg_data;
          thtw_pkg::CFG_RECIP_HEIGHT: recip_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign coord_cfg.recip_width  = recip_width_r;
  assign coord_cfg.recip_height = recip_height_r;
  assign band_cfg.blend_width   = blend_width_r;
  assign band_cfg.band_gap      = band_gap_r;
  assign band_cfg.recip_gap     = recip_gap_r;

  thtw_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .pixel_blue  (in_pixel_blue),
    .pixel_green (in_pixel_green),
    .pixel_red   (in_pixel_red),
    .grid_column (in_grid_column),
    .grid_row    (in_grid_row),
    .coord_cfg   (coord_cfg),
    .front       (front)
  );

  thtw_weights u_weights (
    .clk      (clk),
    .rst_n    (rst_n),
    .band_cfg (band_cfg),
    .front    (front),
    .wgt      (wgt)
  );

  thtw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .wgt   (wgt),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_height_r <= res.side.height;
    out_tex_u_r  <= res.side.tex_u;
    out_tex_v_r  <= res.side.tex_v;
    out_w_r      <= res.zero ? '0 : res.q;
    out_zero_r   <= res.zero;
  end

  assign busy                  = busy_r;
  assign out_valid             = out_valid_r;
  assign out_terrain_height_q8 = out_height_r;
  assign out_tex_u_q16         = out_tex_u_r;
  assign out_tex_v_q16         = out_tex_v_r;
  assign out_weight_sand       = out_w_r[thtw_pkg::LANE_SAND];
  assign out_weight_grass      = out_w_r[thtw_pkg::LANE_GRASS];
  assign out_weight_rock       = out_w_r[thtw_pkg::LANE_ROCK];
  assign out_weight_snow       = out_w_r[thtw_pkg::LANE_SNOW];
  assign out_weights_zero      = out_zero_r;

  assign out_wsum = thtw_pkg::SUM_BITS'(out_weight_sand) + thtw_pkg::SUM_BITS'(out_weight_grass)
                  + thtw_pkg::SUM_BITS'(out_weight_rock) + thtw_pkg::SUM_BITS'(out_weight_snow);

  `THTW_ASSERT_DLY(a_result_follows, in_fire, thtw_pkg::PIPE_LATENCY, out_valid, "transfer lost in pipeline")
  `THTW_ASSERT(a_result_has_source, out_valid, $past(in_fire, thtw_pkg::PIPE_LATENCY), "result without transfer")
  `THTW_ASSERT(a_weights_normalized, out_valid && !out_weights_zero, (out_wsum <= 19'(thtw_pkg::ONE_Q16)) && (out_wsum >= 19'(thtw_pkg::ONE_Q16) - thtw_pkg::NORM_SLACK), "weights not normalized")

endmodule
